// ===== rtl/lrufr_pkg.sv =====
package lrufr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int LINK_W     = $clog2(NUM_FRAMES + 1);
    localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int CMD_W      = 2;

    // Link value that marks the end of the list
    localparam logic [LINK_W-1:0] NULL_MARK = LINK_W'(NUM_FRAMES);

    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNLINK,
        S_PUSH_A,
        S_PUSH_B,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic unlink;
        logic push_a;
        logic push_b;
        logic load_out;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic do_unlink;
        logic do_push;
        logic out_free;
    } t_stat;

    function automatic logic link_valid(input logic [LINK_W-1:0] link);
        return link < NULL_MARK;
    endfunction

endpackage

// ===== rtl/lrufr_ctrl.sv =====
module lrufr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lrufr_pkg::t_stat i_stat,
    output lrufr_pkg::t_ctl  o_ctl
);

    lrufr_pkg::t_state r_state;
    lrufr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrufr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            lrufr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    if (i_stat.do_unlink) begin
                        n_state = lrufr_pkg::S_UNLINK;
                    end else if (i_stat.do_push) begin
                        n_state = lrufr_pkg::S_PUSH_A;
                    end else begin
                        n_state = lrufr_pkg::S_RESULT;
                    end
                end
            end
            lrufr_pkg::S_UNLINK: begin
                o_ctl.unlink = 1'b1;
                n_state      = lrufr_pkg::S_RESULT;
            end
            lrufr_pkg::S_PUSH_A: begin
                o_ctl.push_a = 1'b1;
                n_state      = lrufr_pkg::S_PUSH_B;
            end
            lrufr_pkg::S_PUSH_B: begin
                o_ctl.push_b = 1'b1;
                n_state      = lrufr_pkg::S_RESULT;
            end
            lrufr_pkg::S_RESULT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = lrufr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lrufr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lrufr_dpath.sv =====
module lrufr_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lrufr_pkg::CMD_W-1:0]       i_command,
    input  logic [lrufr_pkg::FRAME_W-1:0]     i_frame,
    input  lrufr_pkg::t_ctl                   i_ctl,
    output lrufr_pkg::t_stat                  o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_found,
    output logic [lrufr_pkg::FRAME_W-1:0]     o_victim_frame,
    output logic [lrufr_pkg::COUNT_W-1:0]     o_member_count
);

    localparam int FW = lrufr_pkg::FRAME_W;
    localparam int LW = lrufr_pkg::LINK_W;
    localparam int CW = lrufr_pkg::COUNT_W;
    localparam int NF = lrufr_pkg::NUM_FRAMES;

    // list links, written on insert before they are ever used
    logic [LW-1:0] r_newer_mem [NF];
    logic [LW-1:0] r_older_mem [NF];

    logic [NF-1:0] r_present;
    logic [LW-1:0] r_newest;
    logic [LW-1:0] r_oldest;
    logic [CW-1:0] r_total;

    logic [FW-1:0] r_target;
    logic [LW-1:0] r_rd_newer;
    logic [LW-1:0] r_rd_older;
    logic          r_res_found;
    logic [FW-1:0] r_res_victim;

    logic          r_out_valid;
    logic          r_out_found;
    logic [FW-1:0] r_out_victim;
    logic [CW-1:0] r_out_count;

    logic          w_oldest_ok;
    logic          w_hit;
    logic [FW-1:0] w_target;
    logic          w_nw_ok;
    logic          w_od_ok;
    logic          w_newest_ok;

    logic          w_newer_we;
    logic [FW-1:0] w_newer_addr;
    logic [LW-1:0] w_newer_data;
    logic          w_older_we;
    logic [FW-1:0] w_older_addr;
    logic [LW-1:0] w_older_data;

    assign w_oldest_ok = lrufr_pkg::link_valid(r_oldest);
    assign w_newest_ok = lrufr_pkg::link_valid(r_newest);
    assign w_hit       = r_present[i_frame];
    assign w_target    = (i_command == lrufr_pkg::CMD_VICTIM) ? r_oldest[FW-1:0] : i_frame;
    assign w_nw_ok     = lrufr_pkg::link_valid(r_rd_newer);
    assign w_od_ok     = lrufr_pkg::link_valid(r_rd_older);

    always_comb begin
        o_stat.do_unlink = ((i_command == lrufr_pkg::CMD_VICTIM) && w_oldest_ok)
                        || ((i_command == lrufr_pkg::CMD_PIN) && w_hit);
        o_stat.do_push   = (i_command == lrufr_pkg::CMD_UNPIN) && !w_hit;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // one write per link memory per cycle
    always_comb begin
        w_newer_we   = 1'b0;
        w_newer_addr = r_target;
        w_newer_data = lrufr_pkg::NULL_MARK;
        w_older_we   = 1'b0;
        w_older_addr = r_target;
        w_older_data = r_newest;
        if (i_ctl.unlink) begin
            w_older_we   = w_nw_ok;
            w_older_addr = r_rd_newer[FW-1:0];
            w_older_data = r_rd_older;
            w_newer_we   = w_od_ok;
            w_newer_addr = r_rd_older[FW-1:0];
            w_newer_data = r_rd_newer;
        end else if (i_ctl.push_a) begin
            w_older_we   = 1'b1;
            w_newer_we   = w_newest_ok;
            w_newer_addr = r_newest[FW-1:0];
            w_newer_data = LW'(r_target);
        end else if (i_ctl.push_b) begin
            w_newer_we   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_newer_we) begin
            r_newer_mem[w_newer_addr] <= w_newer_data;
        end
        if (w_older_we) begin
            r_older_mem[w_older_addr] <= w_older_data;
        end
        r_rd_newer <= r_newer_mem[w_target];
        r_rd_older <= r_older_mem[w_target];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_target     <= w_target;
            r_res_found  <= (i_command == lrufr_pkg::CMD_VICTIM) && w_oldest_ok;
            r_res_victim <= ((i_command == lrufr_pkg::CMD_VICTIM) && w_oldest_ok)
                            ? r_oldest[FW-1:0] : '0;
        end
        if (i_ctl.load_out) begin
            r_out_found  <= r_res_found;
            r_out_victim <= r_res_victim;
            r_out_count  <= r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_newest    <= lrufr_pkg::NULL_MARK;
            r_oldest    <= lrufr_pkg::NULL_MARK;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.unlink) begin
                if (!w_nw_ok) begin
                    r_newest <= r_rd_older;
                end
                if (!w_od_ok) begin
                    r_oldest <= r_rd_newer;
                end
                r_present[r_target] <= 1'b0;
                r_total             <= r_total - CW'(1);
            end else if (i_ctl.push_a) begin
                if (!w_newest_ok) begin
                    r_oldest <= LW'(r_target);
                end
            end else if (i_ctl.push_b) begin
                r_newest            <= LW'(r_target);
                r_present[r_target] <= 1'b1;
                r_total             <= r_total + CW'(1);
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_victim_frame = r_out_victim;
    assign o_member_count = r_out_count;

endmodule

// ===== rtl/lru_frame_replacer_core.sv =====
// LRU frame replacer: an ordered list of evictable frames, newest first.
//
// Input channel (i_in_valid / o_in_ready): one transaction carries a command
// and a frame number. Victim removes and returns the oldest frame, pin removes
// the frame if listed, unpin appends an absent frame at the newest end (a
// frame already listed keeps its place). Unused command codes change nothing.
// Output channel (o_out_valid / i_out_ready): exactly one result transaction
// per command, with found, the victim frame and the member count afterwards.
//
// Steps: accept reads the neighbour links; if the list changes, an unlink
// state (victim, pin) writes both neighbours and the list ends, or the push
// states (insert) make the two writes that the newer-link memory needs; then
// the result state. One item is in work at a time; the output register lets
// the next item enter while the previous result waits to be taken.
//
// Reset clears the membership bits, both list ends and the count at once; the
// link memories need no clearing pass. When the receiver stalls, hold the
// result in the output register; the next result waits in the controller
// until the register frees, and no new item is accepted meanwhile.
module lru_frame_replacer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lrufr_pkg::CMD_W-1:0]       i_command,
    input  logic [lrufr_pkg::FRAME_W-1:0]     i_frame,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [lrufr_pkg::FRAME_W-1:0]     o_victim_frame,
    output logic [lrufr_pkg::COUNT_W-1:0]     o_member_count
);

    lrufr_pkg::t_ctl  w_ctl;
    lrufr_pkg::t_stat w_stat;

    // sequencing of each command
    lrufr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    // link memories, list ends, count and output register
    lrufr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_frame        (i_frame),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_member_count (o_member_count)
    );

`ifndef SYNTHESIS
    // one item at a time: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while previous one still in work");

    // list updates only happen outside the accept cycle
    a_no_update_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.unlink || w_ctl.push_a || w_ctl.push_b) |-> !o_in_ready)
        else $error("list update overlaps an accept");

    // a removed victim leaves room in the list
    a_victim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
        (o_member_count < lrufr_pkg::COUNT_W'(lrufr_pkg::NUM_FRAMES)))
        else $error("victim reported with a full member count");

    // no victim frame without found
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_victim_frame == '0))
        else $error("victim frame set without found");
`endif

endmodule

// ===== tb/lru_frame_replacer_core_test.sv =====
`timescale 1ns / 100ps

module lru_frame_replacer_core_test;

    // Half period 6 ns, so the clock period is 12 ns
    localparam realtime HALF_PERIOD = 6;
    // Give up after this many clock cycles
    localparam int      LIMIT_CYCLES = 400000;
    // Cycles to keep watching the output once nothing is expected
    localparam int      SETTLE_CYCLES = 8;
    // The one command code that the block must treat as a no-op
    localparam logic [lrufr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                            found;
        logic [lrufr_pkg::FRAME_W-1:0]   victim;
        logic [lrufr_pkg::COUNT_W-1:0]   members;
    } t_replacer_result;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            in_valid    = 1'b0;
    logic [lrufr_pkg::CMD_W-1:0]     command     = '0;
    logic [lrufr_pkg::FRAME_W-1:0]   frame       = '0;
    logic                            out_ready   = 1'b0;

    logic                            o_in_ready;
    logic                            o_out_valid;
    logic                            o_found;
    logic [lrufr_pkg::FRAME_W-1:0]   o_victim_frame;
    logic [lrufr_pkg::COUNT_W-1:0]   o_member_count;

    // Shadow copy of the replacer list, newest at the head
    logic                            listed     [lrufr_pkg::NUM_FRAMES];
    logic [lrufr_pkg::LINK_W-1:0]    toward_new [lrufr_pkg::NUM_FRAMES];
    logic [lrufr_pkg::LINK_W-1:0]    toward_old [lrufr_pkg::NUM_FRAMES];
    logic [lrufr_pkg::LINK_W-1:0]    list_head  = lrufr_pkg::NULL_MARK;
    logic [lrufr_pkg::LINK_W-1:0]    list_tail  = lrufr_pkg::NULL_MARK;
    int                              listed_total = 0;

    t_replacer_result   pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int items_sent     = 0;
    int results_checked = 0;
    int peak_members   = 0;
    int fail_count     = 0;

    lru_frame_replacer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (command),
        .i_frame        (frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_member_count (o_member_count)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow list
    // ------------------------------------------------------------------

    // Splice a listed frame out, patching both neighbours or the list ends
    function automatic void detach_frame(input logic [lrufr_pkg::FRAME_W-1:0] f);
        logic [lrufr_pkg::LINK_W-1:0] nw;
        logic [lrufr_pkg::LINK_W-1:0] od;
        nw = toward_new[f];
        od = toward_old[f];
        if (nw < lrufr_pkg::NULL_MARK) toward_old[nw[lrufr_pkg::FRAME_W-1:0]] = od;
        else                           list_head                            = od;
        if (od < lrufr_pkg::NULL_MARK) toward_new[od[lrufr_pkg::FRAME_W-1:0]] = nw;
        else                           list_tail                            = nw;
        listed[f] = 1'b0;
        listed_total--;
    endfunction

    // Apply one command to the shadow list and work out its result
    function automatic t_replacer_result replacer_predict(
        input logic [lrufr_pkg::CMD_W-1:0]   cmd,
        input logic [lrufr_pkg::FRAME_W-1:0] fr
    );
        t_replacer_result               r;
        logic [lrufr_pkg::FRAME_W-1:0]  oldest;
        r.found  = 1'b0;
        r.victim = '0;
        if (cmd == lrufr_pkg::CMD_VICTIM) begin
            if (list_tail < lrufr_pkg::NULL_MARK) begin
                oldest   = list_tail[lrufr_pkg::FRAME_W-1:0];
                r.found  = 1'b1;
                r.victim = oldest;
                detach_frame(oldest);
            end
        end else if ((cmd == lrufr_pkg::CMD_PIN || cmd == lrufr_pkg::CMD_UNPIN)
                     && int'(fr) < lrufr_pkg::NUM_FRAMES) begin
            if (cmd == lrufr_pkg::CMD_PIN) begin
                if (listed[fr]) detach_frame(fr);
            end else if (!listed[fr]) begin
                // Insert at the newest end; a frame already listed keeps its place
                toward_new[fr] = lrufr_pkg::NULL_MARK;
                toward_old[fr] = list_head;
                if (list_head < lrufr_pkg::NULL_MARK)
                    toward_new[list_head[lrufr_pkg::FRAME_W-1:0]] = lrufr_pkg::LINK_W'(fr);
                else
                    list_tail = lrufr_pkg::LINK_W'(fr);
                list_head  = lrufr_pkg::LINK_W'(fr);
                listed[fr] = 1'b1;
                listed_total++;
            end
        end
        r.members = lrufr_pkg::COUNT_W'(listed_total);
        if (listed_total > peak_members) peak_members = listed_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one transaction and return at the edge that accepts it. Valid is
    // left high so that a back-to-back item needs no second assignment in
    // the same step; drop it only when the sender decides to idle.
    task automatic send_command(input logic [lrufr_pkg::CMD_W-1:0]   cmd,
                                input logic [lrufr_pkg::FRAME_W-1:0] fr);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        frame    <= fr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(replacer_predict(cmd, fr));
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall at random or for a long hold-off, and check each
    // result transaction against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_replacer_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b victim=%0d members=%0d",
                         $realtime, o_found, o_victim_frame, o_member_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $realtime, want.found, o_found);
                    fail_count++;
                end
                if (o_victim_frame !== want.victim) begin
                    $display("%0t: victim_frame mismatch, expected %0d, actual %0d",
                             $realtime, want.victim, o_victim_frame);
                    fail_count++;
                end
                if (o_member_count !== want.members) begin
                    $display("%0t: member_count mismatch, expected %0d, actual %0d",
                             $realtime, want.members, o_member_count);
                    fail_count++;
                end
            end
        end
        if (hold_off_left != 0) begin
            out_ready     <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked sequence: empty list, both frame extremes, the unused
    // code, duplicate unpin, pin of an absent frame, removal at each end
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(lrufr_pkg::CMD_VICTIM, 6'd0);     // victim on an empty list
        send_command(lrufr_pkg::CMD_PIN,    6'd0);     // pin of an absent frame
        send_command(lrufr_pkg::CMD_UNPIN,  6'd0);
        send_command(lrufr_pkg::CMD_UNPIN,  6'd63);
        send_command(lrufr_pkg::CMD_UNPIN,  6'd0);     // already listed: no refresh
        send_command(lrufr_pkg::CMD_UNPIN,  6'd42);
        send_command(CMD_UNUSED,            6'd63);    // no-op, count unchanged
        send_command(CMD_UNUSED,            6'd0);
        send_command(lrufr_pkg::CMD_PIN,    6'd63);    // remove from the middle
        send_command(lrufr_pkg::CMD_VICTIM, 6'd63);    // oldest is frame 0
        send_command(lrufr_pkg::CMD_VICTIM, 6'd21);
        send_command(lrufr_pkg::CMD_VICTIM, 6'd0);     // empty again
        send_command(lrufr_pkg::CMD_UNPIN,  6'd5);
        send_command(lrufr_pkg::CMD_UNPIN,  6'd6);
        send_command(lrufr_pkg::CMD_UNPIN,  6'd7);
        send_command(lrufr_pkg::CMD_PIN,    6'd7);     // remove the newest
        send_command(lrufr_pkg::CMD_PIN,    6'd5);     // remove the oldest
        send_command(lrufr_pkg::CMD_PIN,    6'd5);     // second pin finds nothing
        send_command(lrufr_pkg::CMD_VICTIM, 6'd0);     // sole member
        send_command(lrufr_pkg::CMD_UNPIN,  6'd63);
        send_command(lrufr_pkg::CMD_PIN,    6'd63);    // sole member by pin
        send_command(lrufr_pkg::CMD_VICTIM, 6'd0);
        wait_drained();
    endtask

    // Fill every frame in a shuffled order, with repeats, then evict them
    // all and one more, so the full count and the full order are exercised
    task automatic test_fill_and_drain();
        logic [lrufr_pkg::FRAME_W-1:0] order[lrufr_pkg::NUM_FRAMES];
        logic [lrufr_pkg::FRAME_W-1:0] tmp;
        int                            j;
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) order[i] = lrufr_pkg::FRAME_W'(i);
        for (int i = lrufr_pkg::NUM_FRAMES - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
            send_command(lrufr_pkg::CMD_UNPIN, order[i]);
            if ($urandom_range(7) == 0) begin
                j = $urandom_range(i, 0);
                send_command(lrufr_pkg::CMD_UNPIN, order[j]);
            end
        end
        for (int i = 0; i <= lrufr_pkg::NUM_FRAMES; i++) begin
            send_command(lrufr_pkg::CMD_VICTIM, lrufr_pkg::FRAME_W'($urandom));
        end
        wait_drained();
    endtask

    // Mixed commands, mostly on a small set of frames so that pins and
    // duplicate unpins hit listed frames, the rest over the whole range
    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        int                            pick;
        logic [lrufr_pkg::CMD_W-1:0]   cmd;
        logic [lrufr_pkg::FRAME_W-1:0] fr;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 45)      cmd = lrufr_pkg::CMD_UNPIN;
            else if (pick < 70) cmd = lrufr_pkg::CMD_PIN;
            else if (pick < 94) cmd = lrufr_pkg::CMD_VICTIM;
            else                cmd = CMD_UNUSED;
            if ($urandom_range(99) < 70) fr = lrufr_pkg::FRAME_W'($urandom_range(11, 0));
            else                         fr = lrufr_pkg::FRAME_W'($urandom);
            send_command(cmd, fr);
        end
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    // back to back, so the block fills and holds its input; then pause the
    // sender until every result is back and carry on
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left <= 300;
        for (int i = 0; i < 24; i++) begin
            send_command((i % 3 == 2) ? lrufr_pkg::CMD_VICTIM : lrufr_pkg::CMD_UNPIN,
                         lrufr_pkg::FRAME_W'($urandom));
        end
        wait_drained();
        for (int i = 0; i < 6; i++) begin
            send_command(lrufr_pkg::CMD_VICTIM, lrufr_pkg::FRAME_W'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < lrufr_pkg::NUM_FRAMES; i++) begin
            listed[i]     = 1'b0;
            toward_new[i] = lrufr_pkg::NULL_MARK;
            toward_old[i] = lrufr_pkg::NULL_MARK;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_and_drain();
        test_random_mix(55, 0, 0);
        test_random_mix(55, 87, 0);
        test_random_mix(55, 0, 87);
        test_random_mix(55, 27, 27);
        test_backpressure();

        wait_drained();
        // Watch a little longer for any stray result transaction
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands through the replacer and checked %0d results;",
                 items_sent, results_checked);
        $display("list filled to %0d frames under four idle/stall mixes and a long hold-off.",
                 peak_members);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2.0 * HALF_PERIOD * LIMIT_CYCLES);
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
